### hdl/orac_pkg.sv
// Shared types and constants for the overload relay with auto-reclose.
`default_nettype none

package orac_pkg;

  // Protection timing and limits.
  localparam int unsigned MAX_ATTEMPTS   = 3;
  localparam int unsigned CONFIRM_MS     = 2000;
  localparam int unsigned SURVIVED_MS    = 60000;
  localparam int unsigned RETRY_BLOCK_MS = 10000;
  localparam int unsigned MIN_DELAY_S    = 5;
  localparam int unsigned MAX_DELAY_S    = 600;
  localparam int unsigned VA_SCALE       = 10000;
  localparam int unsigned MS_PER_S       = 1000;

  // Field widths.
  localparam int unsigned TS_W     = 32;
  localparam int unsigned VOLT_W   = 12;
  localparam int unsigned CURR_W   = 16;
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned POWER_W  = 28;
  localparam int unsigned VA_W     = 16;
  localparam int unsigned DELAY_W  = 10;
  localparam int unsigned SCALED_W = 30;
  localparam int unsigned DMS_W    = 20;
  localparam int unsigned ATT_W    = $clog2(MAX_ATTEMPTS + 1);
  localparam int unsigned OUT_ATT_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 40;

  // Reset values of the configuration registers.
  localparam int unsigned ALARM_RESET = 2000;
  localparam int unsigned TRIP_RESET  = 2500;
  localparam int signed   TEMP_RESET  = 960;
  localparam int unsigned DELAY_RESET = 30;

  // Status codes as they appear on the result.
  localparam logic [1:0] CODE_NORMAL   = 2'd0;
  localparam logic [1:0] CODE_WARNING  = 2'd1;
  localparam logic [1:0] CODE_OVERLOAD = 2'd2;

  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_CLOSE   = 2'd1,
    OP_OPEN    = 2'd2,
    OP_RESTORE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_VA_ALARM = 2'd0,
    CFG_VA_TRIP  = 2'd1,
    CFG_TEMP     = 2'd2,
    CFG_DELAY    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_NORMAL   = 3'b001,
    ST_WARNING  = 3'b010,
    ST_OVERLOAD = 3'b100
  } state_e;

  // One accepted item after the input register; the product is formed on entry.
  typedef struct packed {
    op_e                     op;
    logic [TS_W-1:0]         now_ms;
    logic [POWER_W-1:0]      power;
    logic                    meter_valid;
    logic signed [TEMP_W-1:0] temperature;
    logic                    temp_valid;
    logic                    restore_locked;
  } item_t;

endpackage

`default_nettype wire

### hdl/overload_relay_autoreclose_unit.sv
// Overload relay with auto-reclose: input register, state update and result register.
// An accepted item passes through the input register and then the result register; the
// state update between them is combinational, and both stages hold while results stall.
// Throughput: one item per cycle while results are taken; the state update is the only loop.
// Reset (asynchronous, active low) clears both stages, returns the relay to normal
// with no lockout, no attempts and all timestamps unset, and restores the default limits.
`default_nettype none

module overload_relay_autoreclose_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [orac_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [orac_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata from bit 0: now_ms[31:0], voltage_dv[43:32], current_ma[59:44],
  // meter_valid[60], temperature[72:61], temp_valid[73], restore_locked[74], zeros.
  input  wire logic [orac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: op[1:0].
  input  wire logic [1:0]                        s_axis_tuser,
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata from bit 0: status[1:0], relay_closed[2], locked[3], attempts_used[5:4],
  // alarm_edge[6], close_refused[7], apparent_power[35:8], zeros.
  output logic [orac_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  localparam int unsigned TS_W    = orac_pkg::TS_W;
  localparam int unsigned ATT_W   = orac_pkg::ATT_W;
  localparam int unsigned POWER_W = orac_pkg::POWER_W;

  // ---------------------------------------------------------------------------
  // Configuration. The VA limits are kept already scaled to 0.0001 VA and the
  // reclose delay already in milliseconds, so the item path has no multiplier
  // beyond the power product.
  // ---------------------------------------------------------------------------
  logic [orac_pkg::SCALED_W-1:0]      alarm_sc_q, trip_sc_q;
  logic signed [orac_pkg::TEMP_W-1:0] temp_limit_q;
  logic [orac_pkg::DMS_W-1:0]         delay_ms_q;
  logic [orac_pkg::DELAY_W-1:0]       delay_wr;
  logic                               delay_ok;

  assign delay_wr = cfg_data_i[orac_pkg::DELAY_W-1:0];
  assign delay_ok = (delay_wr >= orac_pkg::DELAY_W'(orac_pkg::MIN_DELAY_S)) &&
                    (delay_wr <= orac_pkg::DELAY_W'(orac_pkg::MAX_DELAY_S));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_sc_q   <= orac_pkg::SCALED_W'(orac_pkg::ALARM_RESET * orac_pkg::VA_SCALE);
      trip_sc_q    <= orac_pkg::SCALED_W'(orac_pkg::TRIP_RESET * orac_pkg::VA_SCALE);
      temp_limit_q <= orac_pkg::TEMP_W'(orac_pkg::TEMP_RESET);
      delay_ms_q   <= orac_pkg::DMS_W'(orac_pkg::DELAY_RESET * orac_pkg::MS_PER_S);
    end else if (cfg_we_i) begin
      case (orac_pkg::cfg_idx_e'(cfg_idx_i))
        orac_pkg::CFG_VA_ALARM: begin
          alarm_sc_q <= orac_pkg::SCALED_W'(cfg_data_i) *
                        orac_pkg::SCALED_W'(orac_pkg::VA_SCALE);
        end
        orac_pkg::CFG_VA_TRIP: begin
          trip_sc_q <= orac_pkg::SCALED_W'(cfg_data_i) *
                       orac_pkg::SCALED_W'(orac_pkg::VA_SCALE);
        end
        orac_pkg::CFG_TEMP: begin
          temp_limit_q <= cfg_data_i[orac_pkg::TEMP_W-1:0];
        end
        orac_pkg::CFG_DELAY: begin
          // Out-of-range delays leave the old setting in place.
          if (delay_ok) begin
            delay_ms_q <= orac_pkg::DMS_W'(delay_wr) *
                          orac_pkg::DMS_W'(orac_pkg::MS_PER_S);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The update stage fires whenever the input register holds an item
  // and the result register is empty or being emptied this cycle.
  // ---------------------------------------------------------------------------
  logic in_valid_q;
  logic out_valid_q;
  logic fire;
  logic accept;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. The apparent power product is formed on the way in.
  // ---------------------------------------------------------------------------
  orac_pkg::item_t item_q;
  orac_pkg::item_t item_d;

  always_comb begin
    item_d.op             = orac_pkg::op_e'(s_axis_tuser);
    item_d.now_ms         = s_axis_tdata[31:0];
    item_d.power          = POWER_W'(s_axis_tdata[43:32]) * POWER_W'(s_axis_tdata[59:44]);
    item_d.meter_valid    = s_axis_tdata[60];
    item_d.temperature    = s_axis_tdata[72:61];
    item_d.temp_valid     = s_axis_tdata[73];
    item_d.restore_locked = s_axis_tdata[74];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Protection state.
  // ---------------------------------------------------------------------------
  orac_pkg::state_e st_q, st_d;
  logic             lock_q, lock_d;
  logic [ATT_W-1:0] att_q, att_d;
  logic [TS_W-1:0]  trip_q, trip_d;
  logic [TS_W-1:0]  recl_q, recl_d;
  logic [TS_W-1:0]  mclose_q, mclose_d;
  logic [TS_W-1:0]  mblock_q, mblock_d;
  logic [TS_W-1:0]  ots_q, ots_d;

  logic             edge_d, refused_d;
  logic [POWER_W-1:0] power_d;

  // Measurement tests against the scaled limits.
  logic over_alarm, over_trip, below_clear;
  logic [TS_W-1:0] now;
  logic [TS_W-1:0] delay_ms_w;
  logic [TS_W-1:0] since_recl, since_ots, since_trip, since_mclose, since_mblock;

  assign now          = item_q.now_ms;
  assign delay_ms_w   = TS_W'(delay_ms_q);
  assign since_recl   = now - recl_q;
  assign since_trip   = now - trip_q;
  assign since_mclose = now - mclose_q;
  assign since_mblock = now - mblock_q;

  assign over_alarm = (item_q.meter_valid &&
                       (orac_pkg::SCALED_W'(item_q.power) >= alarm_sc_q)) ||
                      (item_q.temp_valid && (item_q.temperature >= temp_limit_q));
  assign over_trip   = item_q.meter_valid &&
                       (orac_pkg::SCALED_W'(item_q.power) >= trip_sc_q);
  assign below_clear = item_q.meter_valid &&
                       (orac_pkg::SCALED_W'(item_q.power) <= alarm_sc_q);

  always_comb begin
    st_d      = st_q;
    lock_d    = lock_q;
    att_d     = att_q;
    trip_d    = trip_q;
    recl_d    = recl_q;
    mclose_d  = mclose_q;
    mblock_d  = mblock_q;
    ots_d     = ots_q;
    edge_d    = 1'b0;
    refused_d = 1'b0;
    power_d   = '0;
    since_ots = '0;

    case (item_q.op)
      orac_pkg::OP_MEASURE: begin
        if (item_q.meter_valid) begin
          power_d = item_q.power;
        end
        // A reclose that has held long enough forgets the earlier attempts.
        if ((att_q != '0) && (st_q != orac_pkg::ST_OVERLOAD) && (recl_q != '0) &&
            (since_recl >= TS_W'(orac_pkg::SURVIVED_MS))) begin
          att_d  = '0;
          recl_d = '0;
        end
        case (st_q)
          orac_pkg::ST_NORMAL: begin
            if (over_alarm) begin
              st_d   = orac_pkg::ST_WARNING;
              ots_d  = over_trip ? now : '0;
              edge_d = 1'b1;
            end
          end
          orac_pkg::ST_WARNING: begin
            if (!over_alarm) begin
              st_d  = orac_pkg::ST_NORMAL;
              ots_d = '0;
            end else if (!over_trip) begin
              ots_d = '0;
            end else begin
              // The confirm timer starts on the first item over the trip level.
              if (ots_q == '0) begin
                ots_d = now;
              end
              since_ots = now - ots_d;
              if (since_ots >= TS_W'(orac_pkg::CONFIRM_MS)) begin
                st_d   = orac_pkg::ST_OVERLOAD;
                trip_d = now;
                // An overload that overrides a recent operator close blocks retries.
                if ((mclose_q != '0) && (since_mclose <= delay_ms_w)) begin
                  mblock_d = now + TS_W'(orac_pkg::RETRY_BLOCK_MS);
                  mclose_d = '0;
                end
              end
            end
          end
          orac_pkg::ST_OVERLOAD: begin
            if (!lock_q && below_clear && (since_trip >= delay_ms_w)) begin
              if (att_d >= ATT_W'(orac_pkg::MAX_ATTEMPTS)) begin
                lock_d = 1'b1;
              end else begin
                att_d  = att_d + ATT_W'(1);
                recl_d = now;
                st_d   = orac_pkg::ST_NORMAL;
                ots_d  = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      orac_pkg::OP_CLOSE: begin
        if (st_q == orac_pkg::ST_OVERLOAD) begin
          // Inside the retry block the wrapped difference is negative.
          if ((mblock_q != '0) && since_mblock[TS_W-1]) begin
            refused_d = 1'b1;
          end else begin
            lock_d   = 1'b0;
            att_d    = '0;
            recl_d   = now;
            mclose_d = now;
            trip_d   = now - delay_ms_w;
            st_d     = orac_pkg::ST_NORMAL;
            ots_d    = '0;
          end
        end
      end
      orac_pkg::OP_OPEN: begin
        if (!((st_q == orac_pkg::ST_OVERLOAD) && lock_q)) begin
          st_d     = orac_pkg::ST_OVERLOAD;
          trip_d   = now;
          lock_d   = 1'b1;
          att_d    = ATT_W'(orac_pkg::MAX_ATTEMPTS);
          recl_d   = '0;
          mclose_d = '0;
        end
      end
      orac_pkg::OP_RESTORE: begin
        st_d   = orac_pkg::ST_OVERLOAD;
        trip_d = now;
        lock_d = item_q.restore_locked;
        att_d  = item_q.restore_locked ? ATT_W'(orac_pkg::MAX_ATTEMPTS) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= orac_pkg::ST_NORMAL;
      lock_q   <= 1'b0;
      att_q    <= '0;
      trip_q   <= '0;
      recl_q   <= '0;
      mclose_q <= '0;
      mblock_q <= '0;
      ots_q    <= '0;
    end else if (fire) begin
      st_q     <= st_d;
      lock_q   <= lock_d;
      att_q    <= att_d;
      trip_q   <= trip_d;
      recl_q   <= recl_d;
      mclose_q <= mclose_d;
      mblock_q <= mblock_d;
      ots_q    <= ots_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [1:0]                    status_code;
  logic [orac_pkg::OUT_ATT_W-1:0] att_out;
  logic [orac_pkg::OUT_DATA_W-1:0] result_d, result_q;

  always_comb begin
    case (st_d)
      orac_pkg::ST_NORMAL:   status_code = orac_pkg::CODE_NORMAL;
      orac_pkg::ST_WARNING:  status_code = orac_pkg::CODE_WARNING;
      orac_pkg::ST_OVERLOAD: status_code = orac_pkg::CODE_OVERLOAD;
      default:               status_code = orac_pkg::CODE_NORMAL;
    endcase
    // The attempt count saturates on the result when the limit exceeds its range.
    if (att_d > ATT_W'({orac_pkg::OUT_ATT_W{1'b1}})) begin
      att_out = '1;
    end else begin
      att_out = orac_pkg::OUT_ATT_W'(att_d);
    end
    result_d        = '0;
    result_d[1:0]   = status_code;
    result_d[2]     = (st_d != orac_pkg::ST_OVERLOAD);
    result_d[3]     = lock_d;
    result_d[5:4]   = att_out;
    result_d[6]     = edge_d;
    result_d[7]     = refused_d;
    result_d[35:8]  = power_d;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tdata = result_q;

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the overload relay with auto-reclose unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import orac_pkg::*;

  // One input item as the stimulus side sees it, before packing into tdata and tuser.
  typedef struct packed {
    op_e              op;
    bit [31:0]        now;
    bit [11:0]        volt;
    bit [15:0]        curr;
    bit               mv;
    bit signed [11:0] temp;
    bit               tv;
    bit               rl;
  } relay_event_t;

  // One result item; the packed layout matches m_axis_tdata[35:0] from the top bit down.
  typedef struct packed {
    bit [27:0] power;
    bit        refused;
    bit        alarm_edge;
    bit [1:0]  attempts;
    bit        locked;
    bit        relay_closed;
    bit [1:0]  status;
  } relay_result_t;

  // Load bands that the random generator holds for a short run of measurements.
  typedef enum {LOAD_LOW, LOAD_BAND, LOAD_TRIP, LOAD_WILD} load_e;

  // The checker keeps its own copy of the limits and of the protection state. Every
  // accepted item advances that copy and queues the response the relay should give.
  class relay_checker;
    bit [15:0]     alarm_va;
    bit [15:0]     trip_va;
    int            temp_lim;
    bit [9:0]      delay_s;
    bit [1:0]      status;
    bit            locked;
    int unsigned   attempts;
    bit [31:0]     trip_at;
    bit [31:0]     reclose_at;
    bit [31:0]     close_at;
    bit [31:0]     block_until;
    bit [31:0]     trip_run_from;
    relay_result_t responses_due[$];
    int            seen;
    int            fails;

    function new();
      alarm_va      = 16'(ALARM_RESET);
      trip_va       = 16'(TRIP_RESET);
      temp_lim      = TEMP_RESET;
      delay_s       = 10'(DELAY_RESET);
      status        = CODE_NORMAL;
      locked        = 1'b0;
      attempts      = 0;
      trip_at       = '0;
      reclose_at    = '0;
      close_at      = '0;
      block_until   = '0;
      trip_run_from = '0;
      seen          = 0;
      fails         = 0;
    endfunction

    function int pending();
      return responses_due.size();
    endfunction

    // A delay outside the allowed window leaves the old delay in place.
    function void set_reg(cfg_idx_e idx, bit [15:0] data);
      case (idx)
        CFG_VA_ALARM: alarm_va = data;
        CFG_VA_TRIP:  trip_va = data;
        CFG_TEMP:     temp_lim = $signed(data[11:0]);
        CFG_DELAY: begin
          if (data[9:0] >= MIN_DELAY_S && data[9:0] <= MAX_DELAY_S) delay_s = data[9:0];
        end
        default: ;
      endcase
    endfunction

    function void take_event(relay_event_t ev);
      relay_result_t   r;
      longint unsigned p;
      longint unsigned alarm_sc;
      longint unsigned trip_sc;
      bit              over_alarm;
      bit              over_trip;
      bit              below_clear;
      bit [31:0]       dms;
      bit [31:0]       lag;
      int              t;
      r        = '0;
      p        = 64'(ev.volt) * 64'(ev.curr);
      alarm_sc = 64'(alarm_va) * 64'(VA_SCALE);
      trip_sc  = 64'(trip_va) * 64'(VA_SCALE);
      t        = $signed(ev.temp);
      dms      = 32'(delay_s) * MS_PER_S;
      case (ev.op)
        OP_MEASURE: begin
          // A missing reading drops out of every power test, so nothing trips or
          // recloses on it; a missing temperature drops out of the alarm test.
          over_alarm  = (ev.mv && p >= alarm_sc) || (ev.tv && t >= temp_lim);
          over_trip   = ev.mv && p >= trip_sc;
          below_clear = ev.mv && p <= alarm_sc;
          if (ev.mv) r.power = p[27:0];
          // A reclose that has held long enough wipes the attempt count.
          lag = ev.now - reclose_at;
          if (attempts > 0 && status != CODE_OVERLOAD && reclose_at != 0 &&
              lag >= SURVIVED_MS) begin
            attempts   = 0;
            reclose_at = '0;
          end
          if (status == CODE_NORMAL) begin
            if (over_alarm) begin
              status        = CODE_WARNING;
              trip_run_from = over_trip ? ev.now : 32'd0;
              r.alarm_edge  = 1'b1;
            end
          end else if (status == CODE_WARNING) begin
            if (!over_alarm) begin
              status        = CODE_NORMAL;
              trip_run_from = '0;
            end else if (!over_trip) begin
              trip_run_from = '0;
            end else begin
              if (trip_run_from == 0) trip_run_from = ev.now;
              lag = ev.now - trip_run_from;
              if (lag >= CONFIRM_MS) begin
                status  = CODE_OVERLOAD;
                trip_at = ev.now;
                // An overload that overrides a recent operator close blocks retries.
                lag = ev.now - close_at;
                if (close_at != 0 && lag <= dms) begin
                  block_until = ev.now + RETRY_BLOCK_MS;
                  close_at    = '0;
                end
              end
            end
          end else begin
            lag = ev.now - trip_at;
            if (!locked && below_clear && lag >= dms) begin
              if (attempts >= MAX_ATTEMPTS) begin
                locked = 1'b1;
              end else begin
                attempts      = attempts + 1;
                reclose_at    = ev.now;
                status        = CODE_NORMAL;
                trip_run_from = '0;
              end
            end
          end
        end
        OP_CLOSE: begin
          // A close outside overload does nothing at all.
          if (status == CODE_OVERLOAD) begin
            lag = ev.now - block_until;
            if (block_until != 0 && lag[31]) begin
              r.refused = 1'b1;
            end else begin
              locked        = 1'b0;
              attempts      = 0;
              reclose_at    = ev.now;
              close_at      = ev.now;
              trip_at       = ev.now - dms;
              status        = CODE_NORMAL;
              trip_run_from = '0;
            end
          end
        end
        OP_OPEN: begin
          if (!(status == CODE_OVERLOAD && locked)) begin
            status     = CODE_OVERLOAD;
            trip_at    = ev.now;
            locked     = 1'b1;
            attempts   = MAX_ATTEMPTS;
            reclose_at = '0;
            close_at   = '0;
          end
        end
        OP_RESTORE: begin
          status   = CODE_OVERLOAD;
          trip_at  = ev.now;
          locked   = ev.rl;
          attempts = ev.rl ? MAX_ATTEMPTS : 0;
        end
        default: ;
      endcase
      r.status       = status;
      r.relay_closed = (status != CODE_OVERLOAD);
      r.locked       = locked;
      r.attempts     = (attempts > 3) ? 2'd3 : 2'(attempts);
      responses_due.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      fails++;
    endtask

    task compare_field(string name, longint got, longint want);
      if (got != want)
        report($sformatf("result %0d: %s is %0d, expected %0d", seen, name, got, want));
    endtask

    task check_response(bit [OUT_DATA_W-1:0] data);
      relay_result_t got;
      relay_result_t want;
      got = data[35:0];
      if (responses_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", seen));
      end else begin
        want = responses_due.pop_front();
        compare_field("status", got.status, want.status);
        compare_field("relay_closed", got.relay_closed, want.relay_closed);
        compare_field("locked", got.locked, want.locked);
        compare_field("attempts_used", got.attempts, want.attempts);
        compare_field("alarm_edge", got.alarm_edge, want.alarm_edge);
        compare_field("close_refused", got.refused, want.refused);
        compare_field("apparent_power", got.power, want.power);
      end
      seen++;
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata from bit 0: now_ms, voltage_dv, current_ma, meter_valid, temperature,
  // temp_valid, restore_locked, zero fill.
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: op.
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata from bit 0: status, relay_closed, locked, attempts_used, alarm_edge,
  // close_refused, apparent_power, zero fill.
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  relay_checker chk = new();

  // Random generator state: the running timestamp and the current load band.
  bit [31:0] stamp     = '0;
  int        load_run  = 0;
  load_e     load_kind = LOAD_LOW;
  // Set for the last part of the run, where neither side idles.
  bit        calm      = 1'b0;

  overload_relay_autoreclose_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Every accepted result is checked against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) chk.check_response(m_axis_tdata);
  end

  // The receiver stalls in random bursts, except in the calm part.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 99) < 10) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // A register write lowers the enable again before it returns, so a
  // following write never drives the enable twice in the same time step.
  task automatic write_reg(cfg_idx_e idx, bit [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    chk.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The bits above the temperature and delay widths carry noise, which the block must ignore.
  task automatic apply_limits(int alarm, int trip, int temp, int delay);
    write_reg(CFG_VA_ALARM, 16'(alarm));
    write_reg(CFG_VA_TRIP, 16'(trip));
    write_reg(CFG_TEMP, {4'($urandom()), 12'(temp)});
    write_reg(CFG_DELAY, {6'($urandom()), 10'(delay)});
  endtask

  // Offers one item, after an optional idle burst, and returns at the edge that took it.
  // Valid is lowered only at the start of a burst, so it never drops and rises in one step.
  task automatic send_item(relay_event_t ev);
    if (!calm && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, ev.rl, ev.tv, ev.temp, ev.mv, ev.curr, ev.volt, ev.now};
    s_axis_tuser  <= ev.op;
    do @(posedge clk_i); while (!s_axis_tready);
    chk.take_event(ev);
  endtask

  // Waits, with a bound, until every predicted result has come.
  task automatic wait_drained();
    int guard = 0;
    while (chk.pending() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic relay_event_t mk(op_e op, bit [31:0] now, int volt, int curr, bit mv,
                                      int temp, bit tv, bit rl);
    relay_event_t ev;
    ev.op   = op;
    ev.now  = now;
    ev.volt = 12'(volt);
    ev.curr = 16'(curr);
    ev.mv   = mv;
    ev.temp = 12'(temp);
    ev.tv   = tv;
    ev.rl   = rl;
    return ev;
  endfunction

  // Random items: the load stays in one band for a short run so that trips get confirmed
  // and recloses happen; timestamps mostly move forward, with rare jumps and zeros.
  function automatic relay_event_t next_item();
    relay_event_t ev;
    int           pick;
    int           lo;
    int           hi;
    int           target;
    int           t;
    longint       amps;
    ev   = '0;
    pick = $urandom_range(0, 99);
    if (pick < 2) stamp = $urandom();
    else if (pick < 4) stamp = stamp;
    else if (pick < 48) stamp = stamp + $urandom_range(100, 800);
    else if (pick < 82) stamp = stamp + $urandom_range(800, 4000);
    else stamp = stamp + $urandom_range(1, int'(chk.delay_s) * 700 + 2000);
    ev.now = ($urandom_range(0, 99) == 0) ? 32'd0 : stamp;

    pick = $urandom_range(0, 99);
    if (pick < 87) ev.op = OP_MEASURE;
    else if (pick < 93) ev.op = OP_CLOSE;
    else if (pick < 96) ev.op = OP_OPEN;
    else ev.op = OP_RESTORE;

    if (load_run == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) load_kind = LOAD_LOW;
      else if (pick < 55) load_kind = LOAD_BAND;
      else if (pick < 90) load_kind = LOAD_TRIP;
      else load_kind = LOAD_WILD;
      load_run = $urandom_range(2, 12);
    end
    load_run--;

    case (load_kind)
      LOAD_LOW: begin
        lo = 0;
        hi = chk.alarm_va;
      end
      LOAD_BAND: begin
        lo = chk.alarm_va;
        hi = (chk.trip_va > chk.alarm_va) ? int'(chk.trip_va) - 1 : int'(chk.alarm_va);
      end
      default: begin
        lo = chk.trip_va;
        hi = int'(chk.trip_va) + 3000;
      end
    endcase
    if (hi > 26000) hi = 26000;
    if (lo > hi) lo = hi;
    target  = lo + int'($urandom_range(0, hi - lo));
    ev.volt = 12'($urandom_range(1200, 4095));
    amps    = (longint'(target) * 10000 + longint'(ev.volt) / 2) / longint'(ev.volt);
    ev.curr = (amps > 65535) ? 16'hFFFF : 16'(amps);
    if (load_kind == LOAD_WILD) begin
      ev.volt = 12'($urandom());
      ev.curr = 16'($urandom());
    end
    ev.mv = ($urandom_range(0, 99) < 93);

    // Temperature mostly stays under the limit so that power decides the state.
    if ($urandom_range(0, 99) < 85 && chk.temp_lim > -880) begin
      hi = (chk.temp_lim > 2000) ? 2000 : chk.temp_lim - 1;
      t  = -880 + int'($urandom_range(0, hi + 880));
    end else begin
      t = -880 + int'($urandom_range(0, 2880));
    end
    ev.temp = 12'(t);
    ev.tv   = ($urandom_range(0, 99) < 90);
    ev.rl   = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // One phase of random items under fixed limits. Somewhere in the middle the sender
  // holds off until every prediction has been met.
  task automatic run_phase(int count);
    int hold_at = $urandom_range(10, count - 10);
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      send_item(next_item());
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset limits: alarm 2000 VA, trip 2500 VA, 60 C, 30 s.
    // Full-scale load at a zero timestamp, so the trip run starts out unset.
    send_item(mk(OP_MEASURE, 0, 4095, 65535, 1, 0, 1, 1));
    send_item(mk(OP_MEASURE, 1000, 4095, 65535, 1, 0, 1, 0));
    send_item(mk(OP_MEASURE, 3000, 4095, 65535, 1, 0, 1, 0));
    // No meter reading: no reclose even though the delay is long past.
    send_item(mk(OP_MEASURE, 40000, 4095, 65535, 0, 2000, 1, 0));
    send_item(mk(OP_MEASURE, 40000, 0, 0, 1, 0, 0, 0));
    // Temperature alone raises the alarm; missing readings then clear it.
    send_item(mk(OP_MEASURE, 41000, 0, 0, 1, 2000, 1, 0));
    send_item(mk(OP_MEASURE, 42000, 0, 0, 0, 2000, 0, 0));
    send_item(mk(OP_MEASURE, 42500, 0, 0, 1, -880, 1, 0));
    // An operator close outside overload is ignored.
    send_item(mk(OP_CLOSE, 43000, 0, 0, 1, 0, 1, 0));
    // Power exactly at the alarm level, then exactly at the trip level.
    send_item(mk(OP_MEASURE, 44000, 2000, 10000, 1, 0, 1, 0));
    send_item(mk(OP_MEASURE, 45000, 2500, 10000, 1, 0, 1, 0));
    send_item(mk(OP_MEASURE, 47000, 2500, 10000, 1, 0, 1, 0));
    // Operator close, then an overload soon after it arms the retry block.
    send_item(mk(OP_CLOSE, 48000, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_MEASURE, 49000, 3000, 10000, 1, 0, 1, 0));
    send_item(mk(OP_MEASURE, 51000, 3000, 10000, 1, 0, 1, 0));
    send_item(mk(OP_CLOSE, 52000, 0, 0, 0, 0, 0, 0));
    // Operator open locks out; a second open while locked out is ignored.
    send_item(mk(OP_OPEN, 53000, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_OPEN, 53100, 0, 0, 0, 0, 0, 1));
    // A close exactly at the end of the block goes through.
    send_item(mk(OP_CLOSE, 61000, 0, 0, 0, 0, 0, 0));
    send_item(mk(OP_RESTORE, 62000, 0, 0, 0, 0, 0, 1));
    send_item(mk(OP_RESTORE, 63000, 0, 0, 0, 0, 0, 0));
    // Reclose with the load exactly at the clear level, then survive long enough.
    send_item(mk(OP_MEASURE, 93000, 2000, 10000, 1, 0, 1, 0));
    send_item(mk(OP_MEASURE, 153000, 0, 0, 1, 0, 1, 0));
    send_item(mk(OP_MEASURE, 153500, 4095, 65535, 1, 2000, 1, 1));
    s_axis_tvalid <= 1'b0;
    wait_drained();

    stamp = 32'd200000;
    apply_limits(2000, 2500, 960, MIN_DELAY_S);
    run_phase(235);

    apply_limits($urandom_range(300, 4000), $urandom_range(300, 7000),
                 $urandom_range(600, 2000), $urandom_range(5, 60));
    run_phase(235);

    // Everything is an alarm and a trip; only zero power clears.
    apply_limits(0, 0, -880, MAX_DELAY_S);
    run_phase(235);

    // Power can never reach these limits; only the hottest probe alarms. The delay
    // writes out of range must all leave 45 s in place.
    apply_limits(65535, 65535, 2000, 45);
    write_reg(CFG_DELAY, 16'd4);
    write_reg(CFG_DELAY, 16'd601);
    write_reg(CFG_DELAY, 16'h03FF);
    write_reg(CFG_DELAY, 16'hFC00);
    run_phase(235);

    // Trip level below the alarm level.
    apply_limits(3000, 1000, 1200, 10);
    run_phase(235);

    // Fully random limits; the delay write may land out of range and be dropped.
    apply_limits($urandom_range(0, 30000), $urandom_range(0, 30000),
                 -880 + int'($urandom_range(0, 2880)), $urandom_range(0, 1023));
    run_phase(235);

    // Timestamps run through the wrap.
    apply_limits(1500, 2200, 900, 20);
    stamp = 32'hFFFF_FFFF - $urandom_range(0, 120000);
    run_phase(235);

    calm = 1'b1;
    apply_limits(2000, 2500, 960, 30);
    run_phase(235);

    if (chk.pending() != 0)
      chk.report($sformatf("%0d results never arrived", chk.pending()));
    if (chk.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner than this.
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
hdl/orac_pkg.sv
hdl/overload_relay_autoreclose_unit.sv
test/tb_top.sv
